FILE: hdl/bqc_pkg.sv
// Shared widths and codes for the cascaded biquad filter.
// No dependencies; imported by the interfaces, the MAC unit, the top level and the testbench.
package bqc_pkg;

  // Field widths
  localparam int SAMPLE_W = 16;   // Q1.15 sample
  localparam int COEF_W   = 18;   // Q3.15 coefficient
  localparam int SIG_W    = 32;   // internal signal word, 15 fraction bits
  localparam int FRAC_W   = 15;
  localparam int PROD_W   = SIG_W + COEF_W;      // exact product
  localparam int RND_W    = PROD_W - FRAC_W;     // product after rounding
  localparam int ACC_W    = RND_W + 1;           // sum of three rounded products
  localparam int CFG_W    = 4;
  localparam int SECF_W   = 3;    // coeff_section field
  localparam int SLOT_W   = 3;    // coeff_slot field

  // Coefficients per section
  localparam int NUM_SLOTS = 5;

  // Coefficient slot codes
  localparam logic [SLOT_W-1:0] SLOT_B1   = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_B2   = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_A1   = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_A2   = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_GAIN = 3'd4;

  // Command codes
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Sequencer steps per section
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] LAST_STEP = 3'd6;

endpackage

FILE: hdl/bqc_if.sv
// Channel interfaces of the cascaded biquad filter: input items, results, register write.
// Depends on bqc_pkg for field widths.
interface bqc_in_if import bqc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic signed [SAMPLE_W-1:0] sample;
  logic                     first_of_block;
  logic [SECF_W-1:0]        coeff_section;
  logic [SLOT_W-1:0]        coeff_slot;
  logic signed [COEF_W-1:0] coeff_value;

  modport source (output valid, cmd, sample, first_of_block, coeff_section, coeff_slot,
                  coeff_value, input ready);
  modport sink   (input valid, cmd, sample, first_of_block, coeff_section, coeff_slot,
                  coeff_value, output ready);
endinterface

interface bqc_out_if import bqc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] filtered;
  logic                       clipped;

  modport source (output valid, filtered, clipped, input ready);
  modport sink   (input valid, filtered, clipped, output ready);
endinterface

interface bqc_cfg_if import bqc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] sections_in_use;

  modport source (output valid, sections_in_use, input ready);
  modport sink   (input valid, sections_in_use, output ready);
endinterface

FILE: hdl/biquad_cascade_iir_filter.sv
// Cascaded direct-form-II biquad filter, top level.
// Depends on bqc_pkg, bqc_if (channels), bqc_ram (coefficient store), bqc_mac.
//
// Usage:
//  item   : input transactions. cmd load writes one Q3.15 coefficient into the
//           store; cmd sample filters one Q1.15 sample. A sample
//           flagged first_of_block clears all section delays before use.
//  result : one transaction per sample: filtered (saturated Q1.15) and clipped.
//  cfg    : sections_in_use, always ready; write only while the block is idle.
// Schedule: with N = min(sections_in_use, MAX_SECTIONS), a sample runs through N
//  sections and then a final step that loads the result register; the input is ready
//  again in the same cycle as the result becomes valid. Each section has a coefficient
//  read lead step, five products on the single shared multiplier issued one a cycle,
//  and a step to finish the sum and write the delay pair. N = 0 sends the sample
//  straight to the final step.
// Reset clears the register, the delays and the coefficient valid bits at once;
//  coefficients never loaded read as zero. No clearing pass is needed.
// A stalled result sits in the output register; the next sample is still taken
//  and waits in its final step until the result register is free.
module biquad_cascade_iir_filter import bqc_pkg::*; #(
  parameter int MAX_SECTIONS = 8
) (
  input  logic       clk,
  input  logic       rst,
  bqc_in_if.sink     item,
  bqc_out_if.source  result,
  bqc_cfg_if.sink    cfg
);

  localparam int DEPTH = NUM_SLOTS * MAX_SECTIONS;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int NW    = $clog2(MAX_SECTIONS + 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_FINAL = 3'b100
  } state_t;

  typedef struct packed {
    logic                    ovf;
    logic signed [SIG_W-1:0] val;
  } sat_sig_t;

  typedef struct packed {
    logic                       ovf;
    logic signed [SAMPLE_W-1:0] val;
  } sat_out_t;

  // saturate the accumulator to a 32-bit signal word
  function automatic sat_sig_t sat_sig(input logic signed [ACC_W-1:0] a);
    sat_sig_t s;
    s.ovf = !((&a[ACC_W-1:SIG_W-1]) || !(|a[ACC_W-1:SIG_W-1]));
    if (s.ovf) begin
      s.val = a[ACC_W-1] ? {1'b1, {(SIG_W-1){1'b0}}} : {1'b0, {(SIG_W-1){1'b1}}};
    end else begin
      s.val = a[SIG_W-1:0];
    end
    return s;
  endfunction

  // saturate the accumulator to the 16-bit output
  function automatic sat_out_t sat_out(input logic signed [ACC_W-1:0] a);
    sat_out_t s;
    s.ovf = !((&a[ACC_W-1:SAMPLE_W-1]) || !(|a[ACC_W-1:SAMPLE_W-1]));
    if (s.ovf) begin
      s.val = a[ACC_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      s.val = a[SAMPLE_W-1:0];
    end
    return s;
  endfunction

  state_t                     state;
  logic [STEP_W-1:0]          step;
  logic [SW-1:0]              sec;
  logic [SW-1:0]              last_sec;
  logic [AW-1:0]              base;
  logic [CFG_W-1:0]           sections_in_use;
  logic [NW-1:0]              n_eff;
  logic signed [SIG_W-1:0]    v;
  logic signed [SIG_W-1:0]    w_reg;
  logic signed [ACC_W-1:0]    acc;
  logic                       clip;
  logic signed [SIG_W-1:0]    delay_one [MAX_SECTIONS];
  logic signed [SIG_W-1:0]    delay_two [MAX_SECTIONS];
  logic [DEPTH-1:0]           cvalid;
  logic                       rd_ok;
  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] res_filtered;
  logic                       res_clipped;

  logic                       in_acc, load_acc, samp_acc, load_ok;
  logic                       out_load;
  logic [31:0]                waddr_full;
  logic [AW-1:0]              wr_addr, rd_addr;
  logic [SLOT_W-1:0]          slot_sel;
  logic [COEF_W-1:0]          rd_data;
  logic signed [COEF_W-1:0]   coef;
  logic signed [SIG_W-1:0]    op;
  logic signed [SIG_W-1:0]    s1, s2;
  logic signed [RND_W-1:0]    mac_rnd;
  logic signed [ACC_W-1:0]    r_x;
  sat_sig_t                   acc_sat;
  sat_out_t                   acc_out;

  // handshakes
  assign item.ready = (state == ST_IDLE);
  assign cfg.ready  = 1'b1;
  assign in_acc     = item.valid && item.ready;
  assign load_acc   = in_acc && (item.cmd == CMD_LOAD);
  assign samp_acc   = in_acc && (item.cmd == CMD_SAMPLE);

  assign result.valid    = out_valid;
  assign result.filtered = res_filtered;
  assign result.clipped  = res_clipped;

  // final step may hand over when the output register is free or being drained
  assign out_load = (state == ST_FINAL) && (!out_valid || result.ready);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      sections_in_use <= '0;
    end else if (cfg.valid && cfg.ready) begin
      sections_in_use <= cfg.sections_in_use;
    end
  end

  // sections actually applied
  always_comb begin
    if (32'(sections_in_use) > MAX_SECTIONS) begin
      n_eff = NW'(MAX_SECTIONS);
    end else begin
      n_eff = NW'(sections_in_use);
    end
  end

  // coefficient write address and range check
  assign waddr_full = 32'(item.coeff_section) * NUM_SLOTS + 32'(item.coeff_slot);
  assign wr_addr    = waddr_full[AW-1:0];
  assign load_ok    = (32'(item.coeff_section) < MAX_SECTIONS) &&
                      (32'(item.coeff_slot) < NUM_SLOTS);

  // read order within a section: gain, a1, a2, b1, b2
  always_comb begin
    unique case (step)
      3'd0:    slot_sel = SLOT_GAIN;
      3'd1:    slot_sel = SLOT_A1;
      3'd2:    slot_sel = SLOT_A2;
      3'd3:    slot_sel = SLOT_B1;
      default: slot_sel = SLOT_B2;
    endcase
  end
  assign rd_addr = base + AW'(slot_sel);

  bqc_ram #(.WIDTH(COEF_W), .DEPTH(DEPTH)) u_coeff_ram (
    .clk   (clk),
    .we    (load_acc && load_ok),
    .waddr (wr_addr),
    .wdata (item.coeff_value),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // entries never written read as zero
  always_ff @(posedge clk) begin
    rd_ok <= cvalid[rd_addr];
  end
  assign coef = rd_ok ? $signed(rd_data) : '0;

  // multiplier operand, paired with the registered coefficient read data
  assign s1 = delay_one[sec];
  assign s2 = delay_two[sec];
  always_comb begin
    unique case (step)
      3'd2, 3'd4: op = s1;
      3'd3, 3'd5: op = s2;
      default:    op = v;
    endcase
  end

  bqc_mac u_mac (
    .clk     (clk),
    .en      (state == ST_RUN),
    .op      (op),
    .coef    (coef),
    .rounded (mac_rnd)
  );

  assign r_x     = ACC_W'(mac_rnd);
  assign acc_sat = sat_sig(acc);
  assign acc_out = sat_out(acc);

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      sec       <= '0;
      clip      <= 1'b0;
      out_valid <= 1'b0;
      cvalid    <= '0;
      for (int i = 0; i < MAX_SECTIONS; i++) begin
        delay_one[i] <= '0;
        delay_two[i] <= '0;
      end
    end else begin
      if (load_acc && load_ok) begin
        cvalid[wr_addr] <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (samp_acc) begin
            if (item.first_of_block) begin
              for (int i = 0; i < MAX_SECTIONS; i++) begin
                delay_one[i] <= '0;
                delay_two[i] <= '0;
              end
            end
            v        <= SIG_W'(item.sample);
            acc      <= ACC_W'(item.sample);
            clip     <= 1'b0;
            sec      <= '0;
            base     <= '0;
            step     <= '0;
            last_sec <= SW'(n_eff - NW'(1));
            state    <= (n_eff == '0) ? ST_FINAL : ST_RUN;
          end
        end

        ST_RUN: begin
          step <= (step == LAST_STEP) ? '0 : step + STEP_W'(1);
          unique case (step)
            3'd0: begin
              // previous section output becomes this section's input
              if (sec != '0) begin
                v    <= acc_sat.val;
                clip <= clip | acc_sat.ovf;
              end
            end
            3'd2: acc <= r_x;
            3'd3, 3'd4: acc <= acc - r_x;
            3'd5: begin
              // w saturated, y sum starts from it
              w_reg <= acc_sat.val;
              acc   <= ACC_W'(acc_sat.val) + r_x;
              clip  <= clip | acc_sat.ovf;
            end
            3'd6: begin
              acc            <= acc + r_x;
              delay_two[sec] <= s1;
              delay_one[sec] <= w_reg;
              if (sec == last_sec) begin
                state <= ST_FINAL;
              end else begin
                sec  <= sec + SW'(1);
                base <= base + AW'(NUM_SLOTS);
              end
            end
            default: ;
          endcase
        end

        ST_FINAL: begin
          // wait for a free output register
          if (out_load) begin
            res_filtered <= acc_out.val;
            res_clipped  <= clip | acc_out.ovf;
            state        <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (step <= LAST_STEP))
    else $error("sequencer step out of range");

  a_sec_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (sec <= last_sec))
    else $error("section index beyond last section in use");

  a_bypass: assert property (@(posedge clk) disable iff (rst)
    (samp_acc && (n_eff == '0)) |=> (state == ST_FINAL))
    else $error("sample with no sections did not go straight to output");

  a_last_section: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && step == LAST_STEP && sec == last_sec) |=> (state == ST_FINAL))
    else $error("last section did not finish the sample");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_FINAL))
    else $error("result raised outside the final step");
`endif

endmodule

FILE: hdl/bqc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bqc_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 40,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/bqc_mac.sv
// Shared multiplier of the biquad sequencer: signal word times coefficient, rounded.
// Depends on bqc_pkg for widths.
module bqc_mac import bqc_pkg::*; (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [SIG_W-1:0]   op,
  input  logic signed [COEF_W-1:0]  coef,
  output logic signed [RND_W-1:0]   rounded
);

  // half an LSB of the result, added before the floor shift
  localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(1) <<< (FRAC_W - 1);

  logic signed [PROD_W-1:0] prod;

  // multiply-add into the product register
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= op * coef + ROUND_BIAS;
    end
  end

  // arithmetic shift by the fraction width: round half up
  assign rounded = prod[PROD_W-1:FRAC_W];

endmodule

FILE: bench/biquad_cascade_iir_filter_tb.sv
// Self-checking testbench for the cascaded biquad filter: a directed table,
// then random coefficient sets and sample blocks, checked by a bit-exact predictor.
// Depends on bqc_pkg, the bqc_if channel interfaces and biquad_cascade_iir_filter.
module biquad_cascade_iir_filter_tb import bqc_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_SECT       = 8;
  localparam int DRAIN_CYCLES = 7 * N_SECT + 12;   // longest sample latency plus margin
  localparam int ITEM_TARGET  = 550;
  localparam longint SIG_MAX  = (longint'(1) <<< 31) - 1;
  localparam longint SIG_MIN  = -(longint'(1) <<< 31);

  typedef struct {
    logic                       cmd;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       fob;
    logic [SECF_W-1:0]          section;
    logic [SLOT_W-1:0]          slot;
    logic signed [COEF_W-1:0]   value;
  } item_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       clipped;
  } output_t;

  // One directed step: either a register write or an input transaction,
  // optionally with a hand-written expected output
  typedef struct {
    bit                         is_cfg;
    logic [CFG_W-1:0]           sections;
    item_t                      it;
    bit                         typed;
    output_t                    known;
  } row_t;

  logic clk;
  logic rst = 1'b1;

  bqc_in_if  item_ch ();
  bqc_out_if res_ch ();
  bqc_cfg_if cfg_ch ();

  biquad_cascade_iir_filter #(.MAX_SECTIONS(N_SECT)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  // Predictor state
  longint           coef_bank [N_SECT*NUM_SLOTS];
  longint           state_s1 [N_SECT];
  longint           state_s2 [N_SECT];
  logic [CFG_W-1:0] cur_sections;

  output_t awaited_outputs [$];
  row_t    directed_rows [$];
  int      mismatches;
  int      items_sent;
  bit      quiet_src;
  bit      quiet_sink;

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("%0t: timeout, %0d outputs still awaited", $time, awaited_outputs.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  // Signal times coefficient, rounded half up to 15 fraction bits
  function automatic longint round_product(input longint s, input longint c);
    return (s * c + 16384) >>> FRAC_W;
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi,
                                   inout bit hit);
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic void store_coefficient(input logic [SECF_W-1:0] sec,
                                            input logic [SLOT_W-1:0] slot,
                                            input logic signed [COEF_W-1:0] val);
    if (sec < N_SECT && slot < NUM_SLOTS)
      coef_bank[sec*NUM_SLOTS + slot] = longint'(val);
  endfunction

  function automatic output_t filter_sample(input logic signed [SAMPLE_W-1:0] x,
                                            input logic clear);
    longint  v, w, yv, s1, s2;
    int      n, k, base;
    bit      hit;
    output_t o;
    hit = 1'b0;
    if (clear) begin
      for (k = 0; k < N_SECT; k++) begin
        state_s1[k] = 0;
        state_s2[k] = 0;
      end
    end
    n = (cur_sections > N_SECT) ? N_SECT : cur_sections;
    v = longint'(x);
    for (k = 0; k < n; k++) begin
      base = k * NUM_SLOTS;
      s1 = state_s1[k];
      s2 = state_s2[k];
      w = round_product(v, coef_bank[base + SLOT_GAIN])
          - round_product(s1, coef_bank[base + SLOT_A1])
          - round_product(s2, coef_bank[base + SLOT_A2]);
      w = clamp(w, SIG_MIN, SIG_MAX, hit);
      yv = w + round_product(s1, coef_bank[base + SLOT_B1])
             + round_product(s2, coef_bank[base + SLOT_B2]);
      yv = clamp(yv, SIG_MIN, SIG_MAX, hit);
      state_s2[k] = s1;
      state_s1[k] = w;
      v = yv;
    end
    v = clamp(v, -32768, 32767, hit);
    o.filtered = v[SAMPLE_W-1:0];
    o.clipped  = hit;
    return o;
  endfunction

  // ---------------------------------------------------------------- drivers

  // Drive one input transaction after a random gap, then update the predictor
  task automatic send_item(input item_t it, input bit typed, input output_t known);
    int      gap;
    output_t o;
    gap = quiet_src ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.cmd   <= it.cmd;
    // fields the command ignores carry random content
    if (it.cmd == CMD_SAMPLE) begin
      item_ch.sample         <= it.sample;
      item_ch.first_of_block <= it.fob;
      item_ch.coeff_section  <= SECF_W'($urandom);
      item_ch.coeff_slot     <= SLOT_W'($urandom);
      item_ch.coeff_value    <= COEF_W'($urandom);
    end else begin
      item_ch.sample         <= SAMPLE_W'($urandom);
      item_ch.first_of_block <= 1'($urandom);
      item_ch.coeff_section  <= it.section;
      item_ch.coeff_slot     <= it.slot;
      item_ch.coeff_value    <= it.value;
    end
    do @(posedge clk); while (!item_ch.ready);
    items_sent++;
    if (it.cmd == CMD_SAMPLE) begin
      o = filter_sample(it.sample, it.fob);
      awaited_outputs.push_back(typed ? known : o);
    end else begin
      store_coefficient(it.section, it.slot, it.value);
    end
  endtask

  task automatic send_load(input logic [SECF_W-1:0] sec, input logic [SLOT_W-1:0] slot,
                           input logic signed [COEF_W-1:0] val);
    item_t   it;
    output_t none;
    it = '{cmd: CMD_LOAD, sample: '0, fob: 1'b0, section: sec, slot: slot, value: val};
    none = '{filtered: '0, clipped: 1'b0};
    send_item(it, 1'b0, none);
  endtask

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] x, input logic fob);
    item_t   it;
    output_t none;
    it = '{cmd: CMD_SAMPLE, sample: x, fob: fob, section: '0, slot: '0, value: '0};
    none = '{filtered: '0, clipped: 1'b0};
    send_item(it, 1'b0, none);
  endtask

  // Register write; only called while the block is idle
  task automatic write_sections(input logic [CFG_W-1:0] n);
    cfg_ch.valid           <= 1'b1;
    cfg_ch.sections_in_use <= n;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cur_sections = n;
  endtask

  // Stop offering input, then wait until every output has arrived and the
  // sequencer has run dry
  task automatic settle_block();
    item_ch.valid <= 1'b0;
    while (awaited_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- random content

  function automatic logic signed [COEF_W-1:0] any_coef();
    case ($urandom_range(0, 7))
      0:       return {1'b1, {(COEF_W-1){1'b0}}};
      1:       return {1'b0, {(COEF_W-1){1'b1}}};
      default: return COEF_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2, 3:    return SAMPLE_W'(int'($urandom_range(0, 4096)) - 2048);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Five loads for one section in rotated slot order; mostly stable poles,
  // sometimes anything at all
  task automatic load_section(input int k);
    logic signed [COEF_W-1:0] c [NUM_SLOTS];
    int a2, lim, start, i, slot;
    if ($urandom_range(0, 3) == 0) begin
      for (i = 0; i < NUM_SLOTS; i++) c[i] = any_coef();
    end else begin
      a2  = int'($urandom_range(0, 58982)) - 29491;
      lim = ((32768 + a2) * 9) / 10;
      c[SLOT_A2]   = COEF_W'(a2);
      c[SLOT_A1]   = COEF_W'(int'($urandom_range(0, 2 * lim)) - lim);
      c[SLOT_GAIN] = COEF_W'(int'($urandom_range(0, 65536)) - 32768);
      c[SLOT_B1]   = COEF_W'(int'($urandom_range(0, 131072)) - 65536);
      c[SLOT_B2]   = COEF_W'(int'($urandom_range(0, 131072)) - 65536);
    end
    start = $urandom_range(0, NUM_SLOTS - 1);
    for (i = 0; i < NUM_SLOTS; i++) begin
      slot = (start + i) % NUM_SLOTS;
      send_load(SECF_W'(k), SLOT_W'(slot), c[slot]);
    end
  endtask

  // ---------------------------------------------------------------- directed table

  task automatic add_row(input bit is_cfg, input logic [CFG_W-1:0] n, input logic cmd,
                         input logic signed [SAMPLE_W-1:0] x, input logic fob,
                         input logic [SECF_W-1:0] sec, input logic [SLOT_W-1:0] slot,
                         input logic signed [COEF_W-1:0] val, input bit typed,
                         input logic signed [SAMPLE_W-1:0] ef, input logic ec);
    row_t r;
    r.is_cfg   = is_cfg;
    r.sections = n;
    r.it       = '{cmd: cmd, sample: x, fob: fob, section: sec, slot: slot, value: val};
    r.typed    = typed;
    r.known    = '{filtered: ef, clipped: ec};
    directed_rows.push_back(r);
  endtask

  task automatic add_sections(input logic [CFG_W-1:0] n);
    add_row(1'b1, n, CMD_SAMPLE, '0, 1'b0, '0, '0, '0, 1'b0, '0, 1'b0);
  endtask

  task automatic add_load(input logic [SECF_W-1:0] sec, input logic [SLOT_W-1:0] slot,
                          input logic signed [COEF_W-1:0] val);
    add_row(1'b0, '0, CMD_LOAD, '0, 1'b0, sec, slot, val, 1'b0, '0, 1'b0);
  endtask

  task automatic add_sample(input logic signed [SAMPLE_W-1:0] x, input logic fob);
    add_row(1'b0, '0, CMD_SAMPLE, x, fob, '0, '0, '0, 1'b0, '0, 1'b0);
  endtask

  task automatic add_known_sample(input logic signed [SAMPLE_W-1:0] x, input logic fob,
                                  input logic signed [SAMPLE_W-1:0] ef, input logic ec);
    add_row(1'b0, '0, CMD_SAMPLE, x, fob, '0, '0, '0, 1'b1, ef, ec);
  endtask

  task automatic build_directed_rows();
    // reset value: no sections, samples pass straight through
    add_known_sample(16'sh7FFF, 1'b0, 16'sh7FFF, 1'b0);
    add_known_sample(16'sh8000, 1'b0, 16'sh8000, 1'b0);
    add_known_sample(16'sh0000, 1'b1, 16'sh0000, 1'b0);
    add_known_sample(-16'sd1,   1'b0, -16'sd1,   1'b0);
    // loads to a slot past the gain are dropped
    add_load(3'd0, 3'd5, 18'sd12345);
    add_load(3'd7, 3'd7, 18'sh20000);
    // one section, unity gain, no feedback
    add_sections(4'd1);
    add_load(3'd0, SLOT_GAIN, 18'sd32768);
    add_known_sample(16'sd16384, 1'b1, 16'sd16384, 1'b0);
    // gain extremes push the output into saturation
    add_load(3'd0, SLOT_GAIN, 18'sh1FFFF);
    add_known_sample(16'sh7FFF, 1'b1, 16'sh7FFF, 1'b1);
    add_known_sample(16'sh8000, 1'b1, 16'sh8000, 1'b1);
    add_load(3'd0, SLOT_GAIN, 18'sh20000);
    add_known_sample(16'sh8000, 1'b1, 16'sh7FFF, 1'b1);
    // feedback and feed-forward coefficients at their extremes
    add_load(3'd0, SLOT_B1, 18'sh1FFFF);
    add_load(3'd0, SLOT_B2, 18'sh20000);
    add_load(3'd0, SLOT_A1, 18'sh20000);
    add_load(3'd0, SLOT_A2, 18'sh1FFFF);
    add_sample(16'sd12345, 1'b1);
    add_sample(-16'sd20000, 1'b0);
    add_sample(16'sd777, 1'b0);
    // register above the section count: all eight sections run
    add_sections(4'd15);
    add_sample(16'sd1000, 1'b1);
    add_sample(-16'sd1, 1'b0);
  endtask

  // ---------------------------------------------------------------- stimulus

  initial begin
    int phase, n, m, k, blocks, b, len, j, r;
    item_ch.valid          <= 1'b0;
    item_ch.cmd            <= CMD_SAMPLE;
    item_ch.sample         <= '0;
    item_ch.first_of_block <= 1'b0;
    item_ch.coeff_section  <= '0;
    item_ch.coeff_slot     <= '0;
    item_ch.coeff_value    <= '0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.sections_in_use <= '0;
    for (k = 0; k < N_SECT * NUM_SLOTS; k++) coef_bank[k] = 0;
    for (k = 0; k < N_SECT; k++) begin
      state_s1[k] = 0;
      state_s2[k] = 0;
    end
    cur_sections = '0;
    mismatches   = 0;
    items_sent   = 0;
    quiet_src    = 1'b0;
    quiet_sink   = 1'b0;
    build_directed_rows();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        settle_block();
        write_sections(directed_rows[i].sections);
      end else begin
        send_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].known);
      end
    end

    // random phases: new section count, fresh coefficients, blocks of samples
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      settle_block();
      case (phase)
        0:       n = N_SECT;
        1:       n = 15;
        2:       n = 0;
        3:       n = 3;
        default: n = $urandom_range(0, 15);
      endcase
      write_sections(CFG_W'(n));
      quiet_src  = ($urandom_range(0, 3) == 0);
      quiet_sink = ($urandom_range(0, 3) == 0);
      m = (n > N_SECT) ? N_SECT : n;
      for (k = 0; k < m; k++) begin
        if (phase == 0 || $urandom_range(0, 2) != 0)
          load_section(k);
      end
      blocks = $urandom_range(1, 4);
      for (b = 0; b < blocks; b++) begin
        len = $urandom_range(1, 40);
        for (j = 0; j < len && items_sent < ITEM_TARGET; j++) begin
          r = $urandom_range(0, 29);
          // occasional bad-slot load or coefficient change mid-block
          if (r == 0)
            send_load(SECF_W'($urandom), SLOT_W'($urandom_range(NUM_SLOTS, 7)), any_coef());
          else if (r == 1)
            send_load(SECF_W'($urandom), SLOT_W'($urandom_range(0, NUM_SLOTS - 1)),
                      any_coef());
          send_sample(pick_sample(), (j == 0) || (r == 2));
        end
      end
      phase++;
    end

    settle_block();
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- output checker

  // Accept result transactions after a random stall and compare with the oldest
  // expectation
  initial begin
    int      stall;
    output_t exp_o;
    res_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      stall = quiet_sink ? 0 : $urandom_range(0, 13);
      if (stall != 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      if (awaited_outputs.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected output filtered=%0d clipped=%0b", $time,
                 res_ch.filtered, res_ch.clipped);
      end else begin
        exp_o = awaited_outputs.pop_front();
        if (res_ch.filtered !== exp_o.filtered) begin
          mismatches++;
          $display("%0t: filtered expected %0d actual %0d", $time, exp_o.filtered,
                   res_ch.filtered);
        end
        if (res_ch.clipped !== exp_o.clipped) begin
          mismatches++;
          $display("%0t: clipped expected %0b actual %0b", $time, exp_o.clipped,
                   res_ch.clipped);
        end
      end
    end
  end

endmodule
